[sv/rstat_pkg.sv]
// Shared definitions for the running statistics block.
// Holds the item kind codes and the state type of the result sequencer.
// Depends on nothing.
package rstat_pkg;

  // Kind field of an input word.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // Result sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_SQR  = 6'b000100,
    ST_DIVM = 6'b001000,
    ST_DIVV = 6'b010000,
    ST_OUT  = 6'b100000
  } back_state_t;

endpackage

[sv/rstat_if.sv]
// Valid/ready channel interfaces for the running statistics block.
// rstat_in_if carries sample and finish words, rstat_out_if carries results.
// Depends on nothing.
interface rstat_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, kind, sample, input ready);
  modport sink (input valid, kind, sample, output ready);
endinterface

interface rstat_out_if #(
  parameter int SAMPLE_BITS   = 16,
  parameter int COUNT_BITS    = 16,
  parameter int FRACTION_BITS = 16
);
  logic                                  valid;
  logic                                  ready;
  logic [COUNT_BITS-1:0]                 count;
  logic [SAMPLE_BITS-1:0]                maximum;
  logic [SAMPLE_BITS-1:0]                minimum;
  logic [SAMPLE_BITS+FRACTION_BITS-1:0]  mean_q16;
  logic [2*SAMPLE_BITS+FRACTION_BITS-3:0] variance_q16;
  logic                                  empty_res;
  logic                                  overflow;

  modport source (output valid, count, maximum, minimum, mean_q16, variance_q16,
                  empty_res, overflow, input ready);
  modport sink (input valid, count, maximum, minimum, mean_q16, variance_q16,
                empty_res, overflow, output ready);
endinterface

[sv/running_statistics_min_max_mean_var.sv]
// Streaming min/max/mean/variance. A sample word is accepted every cycle and
// accumulated through a two-stage front end (square, then add). A finish word
// hands a snapshot of the set to a two-entry queue and clears the set in the
// same cycle, so sampling goes on at once. The result sequencer forms n*sumsq
// and n^2, then sum^2, by shift and add, then runs the bit-serial divider for
// the mean and then the variance, on a dividend of NUM bits, where NUM is
// min(64, 2*SAMPLE_BITS + 2*COUNT_BITS); it takes the next set from the queue
// only once the last result is taken. An empty set presents its result in the
// cycle after it leaves the queue. When the queue is full, a further finish
// word stalls the input until the sequencer frees an entry.
// Depends on rstat_pkg, rstat_if, rstat_front, rstat_queue, rstat_div and
// rstat_back.
module running_statistics_min_max_mean_var #(
  parameter int SAMPLE_BITS   = 16,
  parameter int COUNT_BITS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  rstat_in_if.sink    samples,
  rstat_out_if.source results
);
  localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
  localparam int SQ_BITS  = 2 * SAMPLE_BITS + COUNT_BITS;
  localparam int Q_WIDTH  = COUNT_BITS + SUM_BITS + SQ_BITS + 2 * SAMPLE_BITS + 1;

  logic                   push_valid;
  logic                   push_ready;
  logic                   pop_valid;
  logic                   pop_ready;
  logic [Q_WIDTH-1:0]     push_data;
  logic [Q_WIDTH-1:0]     pop_data;

  logic [COUNT_BITS-1:0]  f_count;
  logic [SUM_BITS-1:0]    f_sum;
  logic [SQ_BITS-1:0]     f_sqsum;
  logic [SAMPLE_BITS-1:0] f_max;
  logic [SAMPLE_BITS-1:0] f_min;
  logic                   f_drop;

  logic [COUNT_BITS-1:0]  e_count;
  logic [SUM_BITS-1:0]    e_sum;
  logic [SQ_BITS-1:0]     e_sqsum;
  logic [SAMPLE_BITS-1:0] e_max;
  logic [SAMPLE_BITS-1:0] e_min;
  logic                   e_drop;

  rstat_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .snap_count (f_count),
    .snap_sum   (f_sum),
    .snap_sqsum (f_sqsum),
    .snap_max   (f_max),
    .snap_min   (f_min),
    .snap_drop  (f_drop)
  );

  assign push_data = {f_count, f_sum, f_sqsum, f_max, f_min, f_drop};

  rstat_queue #(
    .WIDTH (Q_WIDTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign {e_count, e_sum, e_sqsum, e_max, e_min, e_drop} = pop_data;

  rstat_back #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COUNT_BITS    (COUNT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (pop_valid),
    .q_ready (pop_ready),
    .e_count (e_count),
    .e_sum   (e_sum),
    .e_sqsum (e_sqsum),
    .e_max   (e_max),
    .e_min   (e_min),
    .e_drop  (e_drop),
    .results (results)
  );

endmodule

[sv/rstat_front.sv]
// Front end: registers each word with the square of its sample, then
// accumulates count, sum, sum of squares, max and min. A finish word pushes
// a snapshot of the set into the queue and clears it. Depends on rstat_pkg, rstat_if.
module rstat_front #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  rstat_in_if.sink                              samples,
  output logic                                  push_valid,
  input  logic                                  push_ready,
  output logic [COUNT_BITS-1:0]                 snap_count,
  output logic [SAMPLE_BITS+COUNT_BITS-1:0]     snap_sum,
  output logic [2*SAMPLE_BITS+COUNT_BITS-1:0]   snap_sqsum,
  output logic [SAMPLE_BITS-1:0]                snap_max,
  output logic [SAMPLE_BITS-1:0]                snap_min,
  output logic                                  snap_drop
);
  localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
  localparam int SQR_BITS = 2 * SAMPLE_BITS;
  localparam int SQ_BITS  = 2 * SAMPLE_BITS + COUNT_BITS;

  logic                   a_valid;
  logic                   a_kind;
  logic [SAMPLE_BITS-1:0] a_sample;
  logic [SQR_BITS-1:0]    a_square;
  logic [SQR_BITS-1:0]    square;
  logic                   a_take;

  logic [COUNT_BITS-1:0]  sample_count;
  logic [SUM_BITS-1:0]    running_sum;
  logic [SQ_BITS-1:0]     running_square_sum;
  logic [SAMPLE_BITS-1:0] running_max;
  logic [SAMPLE_BITS-1:0] running_min;
  logic                   dropped_flag;

  assign square = SQR_BITS'(samples.sample) * SQR_BITS'(samples.sample);

  // A finish word leaves the register stage only when the queue has room.
  assign a_take = a_valid && ((a_kind == rstat_pkg::KIND_SAMPLE) || push_ready);
  assign samples.ready = !a_valid || a_take;
  assign push_valid = a_valid && (a_kind == rstat_pkg::KIND_FINISH);

  assign snap_count = sample_count;
  assign snap_sum   = running_sum;
  assign snap_sqsum = running_square_sum;
  assign snap_max   = running_max;
  assign snap_min   = running_min;
  assign snap_drop  = dropped_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (samples.valid && samples.ready) begin
      a_valid <= 1'b1;
    end else if (a_take) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      a_kind   <= samples.kind;
      a_sample <= samples.sample;
      a_square <= square;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count       <= '0;
      running_sum        <= '0;
      running_square_sum <= '0;
      running_max        <= '0;
      running_min        <= '1;
      dropped_flag       <= 1'b0;
    end else if (a_take) begin
      if (a_kind == rstat_pkg::KIND_FINISH) begin
        sample_count       <= '0;
        running_sum        <= '0;
        running_square_sum <= '0;
        running_max        <= '0;
        running_min        <= '1;
        dropped_flag       <= 1'b0;
      end else if (sample_count == '1) begin
        dropped_flag <= 1'b1;
      end else begin
        sample_count       <= sample_count + COUNT_BITS'(1);
        running_sum        <= running_sum + SUM_BITS'(a_sample);
        running_square_sum <= running_square_sum + SQ_BITS'(a_square);
        if (a_sample > running_max) begin
          running_max <= a_sample;
        end
        if (a_sample < running_min) begin
          running_min <= a_sample;
        end
      end
    end
  end

endmodule

[sv/rstat_queue.sv]
// Two-entry queue that holds finished set snapshots between the front end
// and the result sequencer. Depends on nothing.
module rstat_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  localparam int DEPTH = 2;

  logic [WIDTH-1:0] mem [DEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != 2'(DEPTH));
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

[sv/rstat_div.sv]
// Restoring divider, one quotient bit per cycle. Returns the low bits of
// floor(dividend * 2^F_BITS / divisor). Depends on nothing.
module rstat_div #(
  parameter int N_BITS = 64,
  parameter int D_BITS = 32,
  parameter int F_BITS = 16,
  parameter int Q_BITS = 46
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [N_BITS-1:0] dividend,
  input  logic [D_BITS-1:0] divisor,
  output logic              done,
  output logic [Q_BITS-1:0] quotient
);
  localparam int TOTAL = N_BITS + F_BITS;
  localparam int CW    = $clog2(TOTAL + 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [TOTAL-1:0]  dvd;
  logic [D_BITS-1:0] dvs;
  logic [D_BITS-1:0] rem;
  logic [Q_BITS-1:0] quo;
  logic [D_BITS:0]   r2;
  logic [D_BITS:0]   diff;
  logic              fits;

  assign r2       = {rem, dvd[TOTAL-1]};
  assign diff     = r2 - {1'b0, dvs};
  assign fits     = (r2 >= {1'b0, dvs});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= CW'(TOTAL);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dvd <= TOTAL'(dividend) << F_BITS;
      dvs <= divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      dvd <= dvd << 1;
      rem <= fits ? diff[D_BITS-1:0] : r2[D_BITS-1:0];
      quo <= {quo[Q_BITS-2:0], fits};
    end
  end

endmodule

[sv/rstat_back.sv]
// Result sequencer: takes a set snapshot, forms n*sumsq - sum^2 and n^2 by
// shift and add, runs the shared divider for mean and variance, and holds the
// result word until it is taken. Depends on rstat_pkg, rstat_if, rstat_div.
module rstat_back #(
  parameter int SAMPLE_BITS   = 16,
  parameter int COUNT_BITS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  output logic                                q_ready,
  input  logic [COUNT_BITS-1:0]               e_count,
  input  logic [SAMPLE_BITS+COUNT_BITS-1:0]   e_sum,
  input  logic [2*SAMPLE_BITS+COUNT_BITS-1:0] e_sqsum,
  input  logic [SAMPLE_BITS-1:0]              e_max,
  input  logic [SAMPLE_BITS-1:0]              e_min,
  input  logic                                e_drop,
  rstat_out_if.source                         results
);
  localparam int SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
  localparam int FULL_BITS = 2 * SAMPLE_BITS + 2 * COUNT_BITS;
  localparam int NUM_BITS  = (FULL_BITS > 64) ? 64 : FULL_BITS;
  localparam int DEN_BITS  = 2 * COUNT_BITS;
  localparam int MEAN_BITS = SAMPLE_BITS + FRACTION_BITS;
  localparam int VAR_BITS  = 2 * SAMPLE_BITS - 2 + FRACTION_BITS;

  rstat_pkg::back_state_t state;

  logic [COUNT_BITS-1:0]  n;
  logic [SUM_BITS-1:0]    sum;
  logic [SAMPLE_BITS-1:0] smax;
  logic [SAMPLE_BITS-1:0] smin;
  logic                   drop;
  logic [NUM_BITS-1:0]    acc;
  logic [NUM_BITS-1:0]    mc;
  logic [DEN_BITS-1:0]    den;
  logic [DEN_BITS-1:0]    mcd;
  logic [COUNT_BITS-1:0]  mp_n;
  logic [SUM_BITS-1:0]    mp_s;
  logic                   div_go;
  logic                   div_done;
  logic [NUM_BITS-1:0]    div_dividend;
  logic [DEN_BITS-1:0]    div_divisor;
  logic [VAR_BITS-1:0]    div_quo;

  logic [COUNT_BITS-1:0]  r_count;
  logic [SAMPLE_BITS-1:0] r_max;
  logic [SAMPLE_BITS-1:0] r_min;
  logic [MEAN_BITS-1:0]   r_mean;
  logic [VAR_BITS-1:0]    r_var;
  logic                   r_empty;
  logic                   r_ovf;

  assign q_ready = (state == rstat_pkg::ST_IDLE);

  assign results.valid        = (state == rstat_pkg::ST_OUT);
  assign results.count        = r_count;
  assign results.maximum      = r_max;
  assign results.minimum      = r_min;
  assign results.mean_q16     = r_mean;
  assign results.variance_q16 = r_var;
  assign results.empty_res    = r_empty;
  assign results.overflow     = r_ovf;

  // The divider is used twice: sum / n for the mean, then numerator / n^2.
  assign div_dividend = (state == rstat_pkg::ST_DIVV) ? acc : NUM_BITS'(sum);
  assign div_divisor  = (state == rstat_pkg::ST_DIVV) ? den : DEN_BITS'(n);

  rstat_div #(
    .N_BITS (NUM_BITS),
    .D_BITS (DEN_BITS),
    .F_BITS (FRACTION_BITS),
    .Q_BITS (VAR_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= rstat_pkg::ST_IDLE;
      div_go <= 1'b0;
    end else begin
      div_go <= 1'b0;
      case (state)
        rstat_pkg::ST_IDLE: begin
          if (q_valid) begin
            state <= (e_count == '0) ? rstat_pkg::ST_OUT : rstat_pkg::ST_MUL;
          end
        end
        rstat_pkg::ST_MUL: begin
          if (mp_n == '0) begin
            state <= rstat_pkg::ST_SQR;
          end
        end
        rstat_pkg::ST_SQR: begin
          if (mp_s == '0) begin
            state  <= rstat_pkg::ST_DIVM;
            div_go <= 1'b1;
          end
        end
        rstat_pkg::ST_DIVM: begin
          if (div_done) begin
            state  <= rstat_pkg::ST_DIVV;
            div_go <= 1'b1;
          end
        end
        rstat_pkg::ST_DIVV: begin
          if (div_done) begin
            state <= rstat_pkg::ST_OUT;
          end
        end
        rstat_pkg::ST_OUT: begin
          if (results.ready) begin
            state <= rstat_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= rstat_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rstat_pkg::ST_IDLE: begin
        if (q_valid) begin
          n    <= e_count;
          sum  <= e_sum;
          smax <= e_max;
          smin <= e_min;
          drop <= e_drop;
          acc  <= '0;
          den  <= '0;
          mc   <= NUM_BITS'(e_sqsum);
          mcd  <= DEN_BITS'(e_count);
          mp_n <= e_count;
          if (e_count == '0) begin
            r_count <= '0;
            r_max   <= '0;
            r_min   <= '0;
            r_mean  <= '0;
            r_var   <= '0;
            r_empty <= 1'b1;
            r_ovf   <= e_drop;
          end
        end
      end
      rstat_pkg::ST_MUL: begin
        // n * sumsq and n * n share the bits of n, low bit first.
        if (mp_n != '0) begin
          if (mp_n[0]) begin
            acc <= acc + mc;
            den <= den + mcd;
          end
          mc   <= mc << 1;
          mcd  <= mcd << 1;
          mp_n <= mp_n >> 1;
        end else begin
          mc   <= NUM_BITS'(sum);
          mp_s <= sum;
        end
      end
      rstat_pkg::ST_SQR: begin
        if (mp_s != '0) begin
          if (mp_s[0]) begin
            acc <= acc - mc;
          end
          mc   <= mc << 1;
          mp_s <= mp_s >> 1;
        end
      end
      rstat_pkg::ST_DIVM: begin
        if (div_done) begin
          r_mean <= div_quo[MEAN_BITS-1:0];
        end
      end
      rstat_pkg::ST_DIVV: begin
        if (div_done) begin
          r_var   <= div_quo;
          r_count <= n;
          r_max   <= smax;
          r_min   <= smin;
          r_empty <= 1'b0;
          r_ovf   <= drop;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
